// ===== hw/rtl/tkde_pkg.sv =====
// Package for the three-key debounce block: item structs, flag bit positions,
// history width and register map. No dependencies.
package tkde_pkg;

  localparam int HIST_BITS  = 8;
  localparam int FLAG_BITS  = 5;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  // flag bit positions
  localparam int BIT_PROG  = 0;
  localparam int BIT_TURN  = 1;
  localparam int BIT_COVER = 2;
  localparam int BIT_LONG  = 3;
  localparam int BIT_EVENT = 4;

  // register index (byte address / 4)
  localparam logic REG_LONG_PRESS = 1'b0;

  localparam logic [COUNT_BITS-1:0] LONG_PRESS_RESET = 16'd3000;

  typedef logic [HIST_BITS-1:0]  hist_t;
  typedef logic [FLAG_BITS-1:0]  flags_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic   prog_pin;
    logic   turn_pin;
    logic   cover_pin;
    flags_t press_clear;
    flags_t release_clear;
  } in_item_t;

  typedef struct packed {
    flags_t press_flags;
    flags_t release_flags;
  } out_item_t;

endpackage

// ===== hw/rtl/tkde_scan.sv =====
// Key scan core: pin histories, turn-key hold counter and sticky flags.
// Depends on tkde_pkg.
module tkde_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  tkde_pkg::in_item_t  item,
  input  tkde_pkg::count_t    long_press_ticks,
  output tkde_pkg::out_item_t result
);

  tkde_pkg::hist_t  prog_hist_r, prog_hist_nxt;
  tkde_pkg::hist_t  turn_hist_r, turn_hist_nxt;
  tkde_pkg::hist_t  cover_hist_r, cover_hist_nxt;
  tkde_pkg::count_t hold_r, hold_nxt;
  tkde_pkg::flags_t press_r, press_nxt;
  tkde_pkg::flags_t release_r, release_nxt;

  always_comb begin
    prog_hist_nxt  = {prog_hist_r[tkde_pkg::HIST_BITS-2:0], item.prog_pin};
    turn_hist_nxt  = {turn_hist_r[tkde_pkg::HIST_BITS-2:0], item.turn_pin};
    cover_hist_nxt = {cover_hist_r[tkde_pkg::HIST_BITS-2:0], item.cover_pin};
    // consumer clears go first so an event raised this tick survives
    press_nxt   = press_r & ~item.press_clear;
    release_nxt = release_r & ~item.release_clear;
    hold_nxt    = hold_r;

    if (prog_hist_nxt == '0 && release_nxt[tkde_pkg::BIT_PROG]) begin
      press_nxt[tkde_pkg::BIT_PROG]   = 1'b1;
      release_nxt[tkde_pkg::BIT_PROG] = 1'b0;
    end
    if (prog_hist_nxt == '1) begin
      release_nxt[tkde_pkg::BIT_PROG] = 1'b1;
    end

    if (turn_hist_nxt == '0) begin
      hold_nxt = hold_r + 1'b1;
      if (release_nxt[tkde_pkg::BIT_TURN]) begin
        press_nxt[tkde_pkg::BIT_TURN]   = 1'b1;
        release_nxt[tkde_pkg::BIT_TURN] = 1'b0;
      end
    end
    if (turn_hist_nxt == '1) begin
      hold_nxt = '0;
      release_nxt[tkde_pkg::BIT_TURN] = 1'b1;
    end
    if (hold_nxt >= long_press_ticks) begin
      hold_nxt = '0;
      press_nxt[tkde_pkg::BIT_LONG] = 1'b1;
    end

    if (cover_hist_nxt == '0) begin
      press_nxt[tkde_pkg::BIT_COVER] = 1'b1;
      if (release_nxt[tkde_pkg::BIT_COVER]) begin
        press_nxt[tkde_pkg::BIT_EVENT]   = 1'b1;
        release_nxt[tkde_pkg::BIT_COVER] = 1'b0;
      end
    end
    if (cover_hist_nxt == '1) begin
      release_nxt[tkde_pkg::BIT_COVER] = 1'b1;
      if (press_nxt[tkde_pkg::BIT_COVER]) begin
        release_nxt[tkde_pkg::BIT_EVENT] = 1'b1;
        press_nxt[tkde_pkg::BIT_COVER]   = 1'b0;
      end
    end
  end

  assign result.press_flags   = press_nxt;
  assign result.release_flags = release_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_hist_r  <= '0;
      turn_hist_r  <= '0;
      cover_hist_r <= '0;
      hold_r       <= '0;
      press_r      <= '0;
      release_r    <= '0;
    end else if (take) begin
      prog_hist_r  <= prog_hist_nxt;
      turn_hist_r  <= turn_hist_nxt;
      cover_hist_r <= cover_hist_nxt;
      hold_r       <= hold_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
    end
  end

endmodule

// ===== hw/rtl/three_key_debounce_events.sv =====
// Three-key debouncer with event flags. One scan request per clock while in_stall
// is low; its flags are registered to out_. The scan and flag update is a single
// registered pass, and a two-deep result buffer (output register plus skid
// entry) lets requests keep arriving while one result waits; in_stall rises only
// when both entries are held. long_press_ticks sits at byte address 0 of the
// APB port and resets to 3000. Depends on tkde_pkg and tkde_scan.
module three_key_debounce_events (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tkde_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tkde_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkde_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tkde_pkg::DATA_BITS-1:0] pwdata,
  output logic [tkde_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  tkde_pkg::count_t    long_press_r;
  tkde_pkg::out_item_t result;
  tkde_pkg::out_item_t out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                take, pop, reg_hit;

  assign reg_hit = (paddr[tkde_pkg::ADDR_BITS-1] == tkde_pkg::REG_LONG_PRESS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit
                 ? {{(tkde_pkg::DATA_BITS-tkde_pkg::COUNT_BITS){1'b0}}, long_press_r}
                 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= tkde_pkg::LONG_PRESS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      long_press_r <= pwdata[tkde_pkg::COUNT_BITS-1:0];
    end
  end

  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pop       = out_valid_r && !out_stall;

  tkde_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .item             (in_data),
    .long_press_ticks (long_press_r),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= take;
          if (take) begin
            skid_r <= result;
          end
        end else begin
          out_valid_r <= take;
          if (take) begin
            out_r <= result;
          end
        end
      end else if (take) begin
        // output held, park the new result
        skid_r       <= result;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tkde_checker.sv =====
// Port-level checker for three_key_debounce_events, bound to the top level.
// Depends on tkde_pkg.
module tkde_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tkde_pkg::out_item_t out_data,
  input logic                pready
);

  // bit 3 of the release flags has no source
  a_rel_bit3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.release_flags[tkde_pkg::BIT_LONG])
    else $error("release flag bit 3 set");

  // after an accepted request out_valid is always high on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // empty output means the buffer is empty, so input is open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind three_key_debounce_events tkde_checker u_tkde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for three_key_debounce_events: drives scan requests and
// APB writes, predicts the debounced flags and compares them. Depends on tkde_pkg.
module testbench;
  import tkde_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_LIMIT = 2000;
  localparam int unsigned LONG_STALL   = 80;
  localparam int unsigned PHASE_SCANS  = 75;
  localparam int unsigned N_PHASES     = 9;
  localparam int unsigned BURST_PHASE  = 3;
  localparam logic [ADDR_BITS-1:0] LONG_PRESS_ADDR = ADDR_BITS'(4 * REG_LONG_PRESS);
  localparam logic [ADDR_BITS-1:0] STRAY_ADDR      = ADDR_BITS'(4 * (REG_LONG_PRESS + 1));

  typedef struct packed {
    logic [2:0] pins;        // {prog, turn, cover}
    flags_t     press_clr;
    flags_t     release_clr;
    logic       typed_in;    // compare against the literal flags below
    flags_t     want_press;
    flags_t     want_release;
  } scan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // predictor state
  hist_t  prog_hist      = '0;
  hist_t  turn_hist      = '0;
  hist_t  cover_hist     = '0;
  count_t hold_cnt       = '0;
  flags_t press_q        = '0;
  flags_t release_q      = '0;
  count_t long_press_cfg = LONG_PRESS_RESET;

  out_item_t   flags_due [$];
  int unsigned mismatch_count = 0;
  int unsigned scan_count     = 0;
  int unsigned flag_count     = 0;
  int unsigned cycle_count    = 0;
  bit          steady_run     = 1'b0;
  bit          stall_request  = 1'b0;

  // random pin generator: each pin holds a level for a run, short runs act as bounce
  logic [2:0] pin_level = '0;
  int         pin_run [3] = '{0, 0, 0};

  scan_row_t scan_plan [22] = '{
    '{3'b000, 5'h00, 5'h00, 1'b1, 5'h04, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b1, 5'h04, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h00, 1'b1, 5'h00, 5'h17},
    '{3'b111, 5'h1F, 5'h1F, 1'b1, 5'h00, 5'h07},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b000, 5'h00, 5'h00, 1'b0, 5'h00, 5'h00},
    // press flags cleared on the tick the events fire: events must survive
    '{3'b000, 5'h1F, 5'h00, 1'b0, 5'h00, 5'h00},
    '{3'b101, 5'h15, 5'h0A, 1'b0, 5'h00, 5'h00},
    '{3'b010, 5'h0A, 5'h15, 1'b0, 5'h00, 5'h00},
    '{3'b111, 5'h00, 5'h1F, 1'b0, 5'h00, 5'h00}
  };

  count_t long_press_plan [8] = '{16'd1, 16'd0, 16'd65535, 16'd4, 16'd25, 16'd2, 16'd12,
                                  16'd3000};

  three_key_debounce_events i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d flag results pending", cycle_count,
             flags_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic out_item_t predict_flags(input in_item_t item);
    out_item_t res;
    press_q &= ~item.press_clear;
    release_q &= ~item.release_clear;
    prog_hist = {prog_hist[HIST_BITS-2:0], item.prog_pin};
    turn_hist = {turn_hist[HIST_BITS-2:0], item.turn_pin};
    cover_hist = {cover_hist[HIST_BITS-2:0], item.cover_pin};

    // one-shot press only after a debounced release
    if (prog_hist == '0 && release_q[BIT_PROG]) begin
      press_q[BIT_PROG] = 1'b1;
      release_q[BIT_PROG] = 1'b0;
    end
    if (prog_hist == '1) release_q[BIT_PROG] = 1'b1;

    if (turn_hist == '0) begin
      hold_cnt = hold_cnt + 1'b1;
      if (release_q[BIT_TURN]) begin
        press_q[BIT_TURN] = 1'b1;
        release_q[BIT_TURN] = 1'b0;
      end
    end
    if (turn_hist == '1) begin
      hold_cnt = '0;
      release_q[BIT_TURN] = 1'b1;
    end
    if (hold_cnt >= long_press_cfg) begin
      hold_cnt = '0;
      press_q[BIT_LONG] = 1'b1;
    end

    if (cover_hist == '0) begin
      press_q[BIT_COVER] = 1'b1;
      if (release_q[BIT_COVER]) begin
        press_q[BIT_EVENT] = 1'b1;
        release_q[BIT_COVER] = 1'b0;
      end
    end
    if (cover_hist == '1) begin
      release_q[BIT_COVER] = 1'b1;
      if (press_q[BIT_COVER]) begin
        release_q[BIT_EVENT] = 1'b1;
        press_q[BIT_COVER] = 1'b0;
      end
    end

    res.press_flags = press_q;
    res.release_flags = release_q;
    return res;
  endfunction

  function automatic int unsigned draw_wait(input bit steady);
    if (steady) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic in_item_t random_scan();
    in_item_t    item;
    logic [31:0] word;
    word = $urandom;
    // occasional pure noise request
    if ($urandom_range(0, 9) == 0) begin
      item = word[$bits(in_item_t)-1:0];
      return item;
    end
    for (int k = 0; k < 3; k++) begin
      if (pin_run[k] == 0) begin
        pin_level[k] = ~pin_level[k];
        pin_run[k] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 48);
      end
      pin_run[k]--;
    end
    item.prog_pin = pin_level[0];
    item.turn_pin = pin_level[1];
    item.cover_pin = pin_level[2];
    case ($urandom_range(0, 7))
      0: begin
        item.press_clear = word[4:0];
        item.release_clear = word[9:5];
      end
      1: begin
        item.press_clear = '1;
        item.release_clear = '1;
      end
      default: begin
        item.press_clear = '0;
        item.release_clear = '0;
      end
    endcase
    return item;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_scan(input in_item_t item, input int unsigned wait_cycles,
                           input bit typed_in, input out_item_t typed_flags);
    out_item_t predicted;
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predicted = predict_flags(item);
    flags_due.push_back(typed_in ? typed_flags : predicted);
    scan_count++;
  endtask

  task automatic settle_flags();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (flags_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (flags_due.size() != 0) begin
      $error("%0d flag results never arrived", flags_due.size());
      mismatch_count++;
      flags_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic hold_turn(input int unsigned ticks);
    in_item_t item;
    repeat (ticks) begin
      item = random_scan();
      item.turn_pin = 1'b0;
      send_scan(item, draw_wait(1'b0), 1'b0, '0);
    end
    // keep the key down into the next setting
    pin_level[1] = 1'b0;
    pin_run[1] = 4;
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_BITS-1:0] addr,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_long_press(input count_t value);
    logic [DATA_BITS-1:0] rd;
    apb_access(1'b0, LONG_PRESS_ADDR, '0, rd);
    if (rd !== DATA_BITS'(value)) begin
      $error("long_press_ticks readback: expected %0d, got %0d", value, rd);
      mismatch_count++;
    end
  endtask

  task automatic set_long_press(input count_t value);
    logic [DATA_BITS-1:0] rd;
    apb_access(1'b1, LONG_PRESS_ADDR, DATA_BITS'(value), rd);
    long_press_cfg = value;
    // write to an unmapped address must leave the register alone
    apb_access(1'b1, STRAY_ADDR, $urandom, rd);
    check_long_press(value);
  endtask

  // result side
  initial begin : flag_sink
    int unsigned hold;
    out_item_t   want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_request) begin
        hold = LONG_STALL;
        stall_request = 1'b0;
      end else begin
        hold = draw_wait(steady_run);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      flag_count++;
      if (flags_due.size() == 0) begin
        $error("flag result %h/%h with no scan request pending", out_data.press_flags,
               out_data.release_flags);
        mismatch_count++;
      end else begin
        want = flags_due.pop_front();
        if (out_data.press_flags !== want.press_flags) begin
          $error("press_flags: expected %h, got %h", want.press_flags, out_data.press_flags);
          mismatch_count++;
        end
        if (out_data.release_flags !== want.release_flags) begin
          $error("release_flags: expected %h, got %h", want.release_flags,
                 out_data.release_flags);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    in_item_t  item;
    out_item_t typed_flags;
    count_t    value;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_long_press(LONG_PRESS_RESET);

    foreach (scan_plan[r]) begin
      item.prog_pin = scan_plan[r].pins[2];
      item.turn_pin = scan_plan[r].pins[1];
      item.cover_pin = scan_plan[r].pins[0];
      item.press_clear = scan_plan[r].press_clr;
      item.release_clear = scan_plan[r].release_clr;
      typed_flags.press_flags = scan_plan[r].want_press;
      typed_flags.release_flags = scan_plan[r].want_release;
      send_scan(item, draw_wait(1'b0), scan_plan[r].typed_in, typed_flags);
    end
    settle_flags();

    for (int p = 0; p < N_PHASES; p++) begin
      hold_turn(12);
      settle_flags();
      if (p < $size(long_press_plan)) value = long_press_plan[p];
      else value = 16'($urandom_range(2, 64));
      set_long_press(value);
      // back-to-back requests while the result side holds off: fills the buffer
      steady_run = (p == BURST_PHASE);
      stall_request = steady_run;
      repeat (PHASE_SCANS) send_scan(random_scan(), draw_wait(steady_run), 1'b0, '0);
      settle_flags();
      steady_run = 1'b0;
    end

    $display("Covered %0d scan requests and %0d flag results across %0d long-press settings,",
             scan_count, flag_count, N_PHASES + 1);
    $display("including thresholds 0, 1 and 65535, back-pressure and mid-hold changes.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tkde_pkg.sv
hw/rtl/tkde_scan.sv
hw/rtl/three_key_debounce_events.sv
hw/rtl/tkde_checker.sv
sim/testbench.sv
